[design/sdr_pkg.sv]
// package: item types, command codes and depth constants for the scanline depth resolver
`timescale 1ns / 1ps

package sdr_pkg;

    // field widths fixed by the item formats
    localparam int DEPTH_W = 32;
    localparam int XL_W    = 10;
    localparam int XR_W    = 11;
    localparam int AW_W    = 11;
    localparam int PID_W   = 16;

    // active width after reset
    localparam logic [AW_W-1:0] ACTIVE_RESET = 11'd1024;

    // saturation bounds of signed q16.16 depth
    localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = 32'sh8000_0000;
    localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 32'sh7fff_ffff;

    // command codes
    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_DRAW  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // one command beat
    typedef struct packed {
        t_cmd                       cmd;
        logic [XL_W-1:0]            x_left;
        logic [XR_W-1:0]            x_right;
        logic signed [DEPTH_W-1:0]  z_start;
        logic signed [DEPTH_W-1:0]  dz_dx;
        logic [PID_W-1:0]           poly_id;
    } t_cmd_item;

    // one result beat
    typedef struct packed {
        logic                       covered;
        logic [PID_W-1:0]           owner_id;
        logic signed [DEPTH_W-1:0]  pixel_depth;
    } t_res_item;

endpackage

[design/sdr_stream_if.sv]
// interface: valid/ready stream channel carrying one payload per beat
`timescale 1ns / 1ps

interface sdr_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[design/sdr_ram.sv]
// generic simple dual-port ram: one write port, one read port with registered read data
`timescale 1ns / 1ps

module sdr_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[design/sdr_depth_unit.sv]
// shared depth unit: strict depth test and saturating depth step
`timescale 1ns / 1ps

module sdr_depth_unit
    import sdr_pkg::*;
(
    input  logic signed [DEPTH_W-1:0] i_z,
    input  logic signed [DEPTH_W-1:0] i_dz,
    input  logic signed [DEPTH_W-1:0] i_stored,
    output logic                      o_wins,
    output logic signed [DEPTH_W-1:0] o_z_next
);

    logic signed [DEPTH_W:0] sum;

    // new depth wins only when strictly nearer
    assign o_wins = (i_z > i_stored);

    // sign-extended add, clamp on overflow
    assign sum = {i_z[DEPTH_W-1], i_z} + {i_dz[DEPTH_W-1], i_dz};

    always_comb begin
        if (sum[DEPTH_W] != sum[DEPTH_W-1]) begin
            o_z_next = sum[DEPTH_W] ? DEPTH_MIN : DEPTH_MAX;
        end else begin
            o_z_next = sum[DEPTH_W-1:0];
        end
    end

endmodule

[design/scanline_depth_resolve.sv]
// top level: scanline depth resolver with line ram, span walker and clearing sweep
`timescale 1ns / 1ps

// Scanline depth resolver. One command beat is taken at a time on i_cmd and every
// command gives exactly one result beat on o_res (zero fields except for a read).
// Depth and owner of every pixel live in one line ram of MAX_WIDTH entries, and a
// single depth unit (strict compare plus saturating step) is reused for each pixel.
// A draw walks one pixel per cycle through the ram's read and write ports, and a
// clear sweeps the whole ram one entry a cycle. After reset the same sweep runs
// over the whole ram before the first command beat is taken. The result sits in an
// output register, so a new command is taken while a result still waits.
// Configuration writes of active_width are taken in any cycle.

module scanline_depth_resolve
    import sdr_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int ID_BITS   = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sdr_stream_if.sink      i_cmd,
    sdr_stream_if.source    o_res,
    input  logic            i_cfg_we,
    input  logic [AW_W-1:0] i_cfg_wdata
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int LIM_W  = (ADDR_W + 1 > XR_W) ? ADDR_W + 1 : XR_W;
    localparam logic [LIM_W-1:0]  MAX_W_L = LIM_W'(MAX_WIDTH);
    localparam logic [ADDR_W-1:0] LAST_X  = ADDR_W'(MAX_WIDTH - 1);

    // one line ram entry
    typedef struct packed {
        logic                      cov;
        logic [ID_BITS-1:0]        id;
        logic signed [DEPTH_W-1:0] depth;
    } t_entry;

    localparam t_entry CLEAR_ENTRY = '{cov: 1'b0, id: '0, depth: DEPTH_MIN};

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DRAW,
        S_READ,
        S_RWAIT,
        S_FINISH
    } t_state;

    t_state              r_state, n_state;
    logic                r_boot, n_boot;
    logic [AW_W-1:0]     r_aw;
    logic [ADDR_W-1:0]   r_clr_x, n_clr_x;
    logic [LIM_W-1:0]    r_rd_x, n_rd_x;
    logic [LIM_W-1:0]    r_lim, n_lim;
    logic                r_cmp_vld, n_cmp_vld;
    logic [ADDR_W-1:0]   r_cmp_x, n_cmp_x;
    logic signed [DEPTH_W-1:0] r_z, n_z;
    logic signed [DEPTH_W-1:0] r_dz, n_dz;
    logic [ID_BITS-1:0]  r_id, n_id;
    t_res_item           r_res, n_res;
    logic                r_out_vld, n_out_vld;
    t_res_item           r_out, n_out;

    // ram ports
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    t_entry              ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    t_entry              ram_rdata;

    // depth unit ports
    logic                du_wins;
    logic signed [DEPTH_W-1:0] du_z_next;

    // command decode helpers
    t_cmd_item           cmd_in;
    logic [LIM_W-1:0]    aw_ext, aw_lim, xr_ext, xl_ext, span_lim;
    logic [ID_BITS+PID_W-1:0] id_in_ext, id_out_ext;

    assign cmd_in = i_cmd.payload;

    // span limit: min(active width, MAX_WIDTH, x_right)
    assign aw_ext   = LIM_W'(r_aw);
    assign aw_lim   = (aw_ext > MAX_W_L) ? MAX_W_L : aw_ext;
    assign xr_ext   = LIM_W'(cmd_in.x_right);
    assign xl_ext   = LIM_W'(cmd_in.x_left);
    assign span_lim = (xr_ext < aw_lim) ? xr_ext : aw_lim;

    // id resizing between the 16-bit fields and the stored ID_BITS
    assign id_in_ext  = {{ID_BITS{1'b0}}, cmd_in.poly_id};
    assign id_out_ext = {{PID_W{1'b0}}, ram_rdata.id};

    assign i_cmd.ready   = (r_state == S_IDLE);
    assign o_res.valid   = r_out_vld;
    assign o_res.payload = r_out;

    sdr_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sdr_depth_unit u_depth (
        .i_z      (r_z),
        .i_dz     (r_dz),
        .i_stored (ram_rdata.depth),
        .o_wins   (du_wins),
        .o_z_next (du_z_next)
    );

    // sequencer next state
    always_comb begin
        n_state   = r_state;
        n_boot    = r_boot;
        n_clr_x   = r_clr_x;
        n_rd_x    = r_rd_x;
        n_lim     = r_lim;
        n_cmp_vld = r_cmp_vld;
        n_cmp_x   = r_cmp_x;
        n_z       = r_z;
        n_dz      = r_dz;
        n_id      = r_id;
        n_res     = r_res;
        n_out     = r_out;
        n_out_vld = r_out_vld;
        ram_we    = 1'b0;
        ram_waddr = r_cmp_x;
        ram_wdata = '{cov: 1'b1, id: r_id, depth: r_z};
        ram_raddr = r_rd_x[ADDR_W-1:0];

        // result beat taken downstream
        if (r_out_vld && o_res.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_x;
                ram_wdata = CLEAR_ENTRY;
                n_clr_x   = r_clr_x + 1'b1;
                if (r_clr_x == LAST_X) begin
                    n_clr_x = '0;
                    n_boot  = 1'b0;
                    n_state = r_boot ? S_IDLE : S_FINISH;
                end
            end
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_res = '0;
                    case (cmd_in.cmd)
                        CMD_CLEAR: begin
                            n_clr_x = '0;
                            n_state = S_CLEAR;
                        end
                        CMD_DRAW: begin
                            n_rd_x    = xl_ext;
                            n_lim     = span_lim;
                            n_cmp_vld = 1'b0;
                            n_z       = cmd_in.z_start;
                            n_dz      = cmd_in.dz_dx;
                            n_id      = id_in_ext[ID_BITS-1:0];
                            n_state   = S_DRAW;
                        end
                        CMD_READ: begin
                            n_rd_x = xl_ext;
                            if (xl_ext < MAX_W_L) begin
                                n_state = S_READ;
                            end else begin
                                n_res.pixel_depth = DEPTH_MIN;
                                n_state           = S_FINISH;
                            end
                        end
                        default: begin
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end
            S_DRAW: begin
                // compare and write back the pixel read last cycle
                if (r_cmp_vld) begin
                    ram_we = du_wins;
                    n_z    = du_z_next;
                end
                // read the next pixel of the span
                if (r_rd_x < r_lim) begin
                    n_cmp_vld = 1'b1;
                    n_cmp_x   = r_rd_x[ADDR_W-1:0];
                    n_rd_x    = r_rd_x + 1'b1;
                end else begin
                    n_cmp_vld = 1'b0;
                    if (!r_cmp_vld) begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_READ: begin
                n_state = S_RWAIT;
            end
            S_RWAIT: begin
                n_res.covered     = ram_rdata.cov;
                n_res.owner_id    = ram_rdata.cov ? id_out_ext[PID_W-1:0] : '0;
                n_res.pixel_depth = ram_rdata.depth;
                n_state           = S_FINISH;
            end
            S_FINISH: begin
                // load the output register once it is free
                if (!r_out_vld || o_res.ready) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_boot    <= 1'b1;
            r_clr_x   <= '0;
            r_rd_x    <= '0;
            r_lim     <= '0;
            r_cmp_vld <= 1'b0;
            r_cmp_x   <= '0;
            r_z       <= '0;
            r_dz      <= '0;
            r_id      <= '0;
            r_res     <= '0;
            r_out_vld <= 1'b0;
            r_out     <= '0;
        end else begin
            r_state   <= n_state;
            r_boot    <= n_boot;
            r_clr_x   <= n_clr_x;
            r_rd_x    <= n_rd_x;
            r_lim     <= n_lim;
            r_cmp_vld <= n_cmp_vld;
            r_cmp_x   <= n_cmp_x;
            r_z       <= n_z;
            r_dz      <= n_dz;
            r_id      <= n_id;
            r_res     <= n_res;
            r_out_vld <= n_out_vld;
            r_out     <= n_out;
        end
    end

    // active width register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aw <= ACTIVE_RESET;
        end else if (i_cfg_we) begin
            r_aw <= i_cfg_wdata;
        end
    end

endmodule

[bench/scanline_depth_resolve_tb.sv]
// testbench: random and directed span, read and clear beats checked against a line model
`timescale 1ns / 1ps

module scanline_depth_resolve_tb;
    import sdr_pkg::*;

    localparam int     LINE_PX     = 1024;
    localparam int     HOLD_CYCLES = 2500;
    localparam longint TIMEOUT_NS  = 100_000_000;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            cfg_we;
    logic [AW_W-1:0] cfg_wdata;

    sdr_stream_if #(.t_payload(t_cmd_item)) cmd_if ();
    sdr_stream_if #(.t_payload(t_res_item)) res_if ();

    // expected line contents and active width
    logic signed [DEPTH_W-1:0] depth_line [LINE_PX];
    logic [PID_W:0]            owner_line [LINE_PX];
    logic [AW_W-1:0]           active_px;

    t_cmd_item cmd_backlog[$];
    t_res_item pixel_expect_q[$];

    int gap_pct      = 0;
    int stall_pct    = 0;
    int mismatch_cnt = 0;
    bit hold_req     = 1'b0;
    bit res_hold     = 1'b0;

    scanline_depth_resolve #(
        .MAX_WIDTH (LINE_PX),
        .ID_BITS   (PID_W)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cmd       (cmd_if),
        .o_res       (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    task automatic flag_mismatch(input string what);
        mismatch_cnt++;
        $display("mismatch %0d at %0t: %s", mismatch_cnt, $realtime, what);
    endtask

    // apply one accepted command beat to the line and queue its result
    task automatic resolve_line_cmd(input t_cmd_item it);
        t_res_item r;
        longint    run_z;
        longint    step;
        int        lim;
        r = '0;
        case (it.cmd)
            CMD_CLEAR: begin
                for (int i = 0; i < LINE_PX; i++) begin
                    depth_line[i] = DEPTH_MIN;
                    owner_line[i] = '0;
                end
            end
            CMD_DRAW: begin
                lim = (active_px > LINE_PX) ? LINE_PX : int'(active_px);
                if (int'(it.x_right) < lim)
                    lim = int'(it.x_right);
                run_z = $signed(it.z_start);
                step  = $signed(it.dz_dx);
                for (int x = int'(it.x_left); x < lim; x++) begin
                    // strictly nearer depth takes the pixel
                    if (run_z > longint'($signed(depth_line[x]))) begin
                        depth_line[x] = run_z[DEPTH_W-1:0];
                        owner_line[x] = {1'b1, it.poly_id};
                    end
                    run_z = run_z + step;
                    if (run_z > DEPTH_MAX)
                        run_z = DEPTH_MAX;
                    else if (run_z < DEPTH_MIN)
                        run_z = DEPTH_MIN;
                end
            end
            CMD_READ: begin
                r.covered     = owner_line[it.x_left][PID_W];
                r.owner_id    = r.covered ? owner_line[it.x_left][PID_W-1:0] : '0;
                r.pixel_depth = depth_line[it.x_left];
            end
            default: ;
        endcase
        pixel_expect_q = {pixel_expect_q, r};
    endtask

    task automatic post_cmd(input t_cmd c, input int xl, input int xr,
                            input logic [31:0] z, input logic [31:0] dz,
                            input logic [31:0] id);
        t_cmd_item it;
        it.cmd     = c;
        it.x_left  = xl[XL_W-1:0];
        it.x_right = xr[XR_W-1:0];
        it.z_start = z;
        it.dz_dx   = dz;
        it.poly_id = id[PID_W-1:0];
        cmd_backlog = {cmd_backlog, it};
    endtask

    task automatic set_active_width(input logic [AW_W-1:0] width);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= width;
        @(posedge clk);
        cfg_we    <= 1'b0;
        active_px = width;
        @(negedge clk);
    endtask

    task automatic wait_line_idle();
        do
            @(negedge clk);
        while (cmd_backlog.size() != 0 || cmd_if.valid || pixel_expect_q.size() != 0);
    endtask

    // mostly spans and reads around a busy window, with some clears and noise
    task automatic queue_random_cmds(input int count);
        int          hot;
        int          xl;
        int          xr;
        int          pick;
        int          aw_eff;
        logic [31:0] z;
        logic [31:0] dz;
        aw_eff = (active_px > LINE_PX) ? LINE_PX : int'(active_px);
        hot    = 0;
        for (int n = 0; n < count; n++) begin
            // move the window now and then, often onto the active edge
            if (n % 24 == 0) begin
                if ($urandom_range(99) < 35 && aw_eff > 0)
                    hot = (aw_eff > 32) ? aw_eff - 32 : 0;
                else
                    hot = $urandom_range(0, LINE_PX - 64);
                if (hot > LINE_PX - 64)
                    hot = LINE_PX - 64;
            end
            pick = $urandom_range(99);
            if (pick < 4) begin
                post_cmd(CMD_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 2047),
                         $urandom, $urandom, $urandom);
            end else if (pick < 7) begin
                post_cmd(CMD_NONE, $urandom_range(0, 1023), $urandom_range(0, 2047),
                         $urandom, $urandom, $urandom);
            end else if (pick < 50) begin
                // span placement
                pick = $urandom_range(99);
                if (pick < 85) begin
                    xl = hot + $urandom_range(0, 63);
                    xr = xl + $urandom_range(0, 40);
                    if (xr > LINE_PX)
                        xr = LINE_PX;
                end else if (pick < 93) begin
                    xl = $urandom_range(0, LINE_PX - 1);
                    xr = $urandom_range(0, LINE_PX);
                end else begin
                    xl = $urandom_range(0, 31);
                    xr = $urandom_range(LINE_PX - 64, LINE_PX);
                end
                // depth profile
                pick = $urandom_range(99);
                if (pick < 70) begin
                    z  = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
                    dz = $urandom_range(0, 32'h0000_8000) - 32'h0000_4000;
                end else if (pick < 85) begin
                    z  = $urandom;
                    dz = $urandom;
                end else if (pick < 95) begin
                    if ($urandom_range(1) == 1) begin
                        z  = DEPTH_MAX - $urandom_range(0, 32'h00ff_ffff);
                        dz = $urandom_range(32'h0100_0000, 32'h7fff_ffff);
                    end else begin
                        z  = $urandom_range(0, 32'h0fff_ffff);
                        dz = 32'h8000_0000 + $urandom_range(0, 32'h00ff_ffff);
                    end
                end else begin
                    z  = DEPTH_MIN;
                    dz = $urandom_range(0, 32'h0000_ffff);
                end
                post_cmd(CMD_DRAW, xl, xr, z, dz, $urandom);
            end else begin
                xl = ($urandom_range(99) < 75) ? hot + $urandom_range(0, 63)
                                               : $urandom_range(0, LINE_PX - 1);
                post_cmd(CMD_READ, xl, $urandom_range(0, 2047), $urandom, $urandom, $urandom);
            end
        end
    endtask

    // each phase starts from an idle block: width write, idling mix, then beats
    task automatic run_phase(input logic [AW_W-1:0] width, input int gap, input int stall,
                             input int count, input bit starve);
        wait_line_idle();
        repeat (3) @(negedge clk);
        gap_pct   = gap;
        stall_pct = stall;
        set_active_width(width);
        if (starve)
            hold_req = 1'b1;
        queue_random_cmds(count);
    endtask

    // command beat driver, prediction on acceptance
    always @(posedge clk) begin : cmd_driver
        bit offer;
        if (!rst_n) begin
            cmd_if.valid <= 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready)
                resolve_line_cmd(cmd_if.payload);
            if (!cmd_if.valid || cmd_if.ready) begin
                offer = (cmd_backlog.size() != 0) && ($urandom_range(99) >= gap_pct);
                cmd_if.valid <= offer;
                if (offer)
                    cmd_if.payload <= cmd_backlog.pop_front();
            end
        end
    end

    // result beat monitor and receiver stalls
    always @(posedge clk) begin : res_monitor
        t_res_item want;
        if (!rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (pixel_expect_q.size() == 0) begin
                    flag_mismatch("result beat with nothing outstanding");
                end else begin
                    want = pixel_expect_q.pop_front();
                    if (res_if.payload.covered !== want.covered)
                        flag_mismatch($sformatf("covered got %0b want %0b",
                                                res_if.payload.covered, want.covered));
                    if (res_if.payload.owner_id !== want.owner_id)
                        flag_mismatch($sformatf("owner_id got %h want %h",
                                                res_if.payload.owner_id, want.owner_id));
                    if (res_if.payload.pixel_depth !== want.pixel_depth)
                        flag_mismatch($sformatf("pixel_depth got %h want %h",
                                                res_if.payload.pixel_depth, want.pixel_depth));
                end
            end
            res_if.ready <= !res_hold && ($urandom_range(99) >= stall_pct);
        end
    end

    // long receiver hold-off so the block backs up onto its input
    always begin : receiver_hold
        wait (hold_req);
        @(posedge clk);
        res_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        res_hold <= 1'b0;
        hold_req = 1'b0;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("scanline_depth_resolve_tb failed");
        $finish;
    end

    initial begin : stimulus
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        cmd_if.valid   = 1'b0;
        cmd_if.payload = '0;
        res_if.ready   = 1'b0;
        for (int i = 0; i < LINE_PX; i++) begin
            depth_line[i] = DEPTH_MIN;
            owner_line[i] = '0;
        end
        active_px = ACTIVE_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_active_width(ACTIVE_RESET);
        // untouched line reads as background at both ends
        post_cmd(CMD_READ, 0, 0, 0, 0, 0);
        post_cmd(CMD_READ, 1023, 0, 0, 0, 0);
        // most negative depth never beats the cleared line
        post_cmd(CMD_DRAW, 30, 40, DEPTH_MIN, 0, 32'h0000_0001);
        post_cmd(CMD_READ, 35, 0, 0, 0, 0);
        // full-width span at depth zero
        post_cmd(CMD_DRAW, 0, 1024, 0, 0, 32'h0000_ffff);
        post_cmd(CMD_READ, 0, 0, 0, 0, 0);
        post_cmd(CMD_READ, 1023, 0, 0, 0, 0);
        // equal depth leaves the owner alone
        post_cmd(CMD_DRAW, 0, 8, 0, 0, 32'h0000_00aa);
        post_cmd(CMD_READ, 4, 0, 0, 0, 0);
        // running depth saturates upwards
        post_cmd(CMD_DRAW, 100, 110, 32'h7fff_0000, DEPTH_MAX, 32'h0000_1234);
        post_cmd(CMD_READ, 100, 0, 0, 0, 0);
        post_cmd(CMD_READ, 105, 0, 0, 0, 0);
        // one winning pixel then saturation downwards
        post_cmd(CMD_DRAW, 200, 206, 32'h0000_0001, DEPTH_MIN, 32'h0000_a5a5);
        post_cmd(CMD_READ, 200, 0, 0, 0, 0);
        post_cmd(CMD_READ, 201, 0, 0, 0, 0);
        // empty and reversed spans
        post_cmd(CMD_DRAW, 500, 500, DEPTH_MAX, 0, 32'h0000_5555);
        post_cmd(CMD_DRAW, 600, 3, DEPTH_MAX, 0, 32'h0000_5555);
        post_cmd(CMD_READ, 500, 0, 0, 0, 0);
        // unused command code
        post_cmd(CMD_NONE, 1023, 2047, $urandom, $urandom, 32'h0000_ffff);
        // last pixel, id zero still marks it covered
        post_cmd(CMD_DRAW, 1023, 1024, 32'h0000_0005, 0, 32'h0000_0000);
        post_cmd(CMD_READ, 1023, 0, 0, 0, 0);
        // clear brings the whole line back
        post_cmd(CMD_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 2047),
                 $urandom, $urandom, $urandom);
        post_cmd(CMD_READ, 0, 0, 0, 0, 0);
        post_cmd(CMD_READ, 1023, 0, 0, 0, 0);

        run_phase(11'd1, 0, 0, 100, 1'b0);
        run_phase(11'($urandom_range(2, 1023)), 52, 0, 150, 1'b0);
        run_phase(11'd2047, 0, 52, 150, 1'b0);
        run_phase(11'd0, 14, 14, 60, 1'b0);
        run_phase(11'($urandom_range(64, 1000)), 14, 14, 150, 1'b0);
        run_phase(ACTIVE_RESET, 0, 0, 60, 1'b1);
        run_phase(11'($urandom_range(1, 1024)), 0, 52, 150, 1'b0);
        run_phase(ACTIVE_RESET, 0, 0, 180, 1'b0);

        // drain, then let any stray beat show up
        wait_line_idle();
        repeat (LINE_PX + 16) @(negedge clk);
        if (mismatch_cnt == 0)
            $display("scanline_depth_resolve_tb passed");
        else
            $display("scanline_depth_resolve_tb failed");
        $finish;
    end

endmodule
